### rtl/priority_queue_max_scan_top_macros.svh
// ---------------------------------------------------------------------------
// Priority queue assertion macros
// Shared assertion helpers for the priority queue RTL.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_MAX_SCAN_TOP_MACROS_SVH
`define PRIORITY_QUEUE_MAX_SCAN_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PQMS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pqms: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PQMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pqms: assertion failed");
`else
`define PQMS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define PQMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/pqms_pkg.sv
// ---------------------------------------------------------------------------
// Priority queue package
// Types and constants shared by the priority queue modules.
// ---------------------------------------------------------------------------
package pqms_pkg;

  localparam int unsigned COUNT_W = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_remove;
    logic empty;
    logic scan_done;
    logic shift_done;
  } stat_t;

endpackage

### rtl/pqms_if.sv
// ---------------------------------------------------------------------------
// Priority queue channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pqms_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] value;
  logic signed [15:0] priority_req;

  modport source (output valid, output action, output value, output priority_req,
                  input ready);
  modport sink (input valid, input action, input value, input priority_req,
                output ready);
endinterface

interface pqms_rsp_if;
  logic                                 valid;
  logic                                 ready;
  pqms_pkg::status_e                    status;
  logic signed [31:0]                   removed_value;
  logic signed [15:0]                   removed_priority;
  logic [pqms_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output removed_value,
                  output removed_priority, output count, input ready);
  modport sink (input valid, input status, input removed_value,
                input removed_priority, input count, output ready);
endinterface

### rtl/pqms_ctrl.sv
// ---------------------------------------------------------------------------
// Priority queue controller
// Sequences insert, scan, shift and result hand-off for one beat at a time.
// ---------------------------------------------------------------------------
module pqms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pqms_pkg::stat_t stat_i,
  output pqms_pkg::cmd_t  cmd_o
);
  import pqms_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_SCAN       = 5'b00010,
    S_SHIFT_INIT = 5'b00100,
    S_SHIFT      = 5'b01000,
    S_DONE       = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = (stat_i.in_remove && !stat_i.empty) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_SHIFT_INIT;
        end
      end
      S_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        state_d          = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/pqms_datapath.sv
// ---------------------------------------------------------------------------
// Priority queue datapath
// Entry memory, fill count, maximum scan, gap shift and result register.
// ---------------------------------------------------------------------------
`include "priority_queue_max_scan_top_macros.svh"

module pqms_datapath #(
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pqms_pkg::cmd_t                cmd_i,
  output pqms_pkg::stat_t               stat_o,
  input  logic                          in_action_i,
  input  logic signed [31:0]            in_value_i,
  input  logic signed [15:0]            in_priority_req_i,
  output pqms_pkg::status_e             out_status_o,
  output logic signed [31:0]            out_removed_value_o,
  output logic signed [15:0]            out_removed_priority_o,
  output logic [pqms_pkg::COUNT_W-1:0]  out_count_o
);
  import pqms_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  entry_t          mem_q [DEPTH];
  entry_t          rdata_q;
  entry_t          wdata;
  entry_t          best_q;
  logic [AW-1:0]   best_idx_q;
  logic [AW-1:0]   waddr;
  logic            we;
  logic            re;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   idx_d1_q;
  logic            vld_d1_q, vld_d1_d;
  logic            full;
  logic            req_action_q;
  status_e         res_status;
  logic            take_best;

  status_e            out_status_q;
  logic signed [31:0] out_value_q;
  logic signed [15:0] out_prio_q;
  logic [COUNT_W-1:0] out_count_q;

  assign full = (fill_q == CW'(DEPTH));
  assign re   = (cmd_i.scan || cmd_i.shift) && (idx_q < fill_q);

  always_comb begin
    we    = 1'b0;
    waddr = fill_q[AW-1:0];
    wdata = '{value: in_value_i, prio: in_priority_req_i};
    if (cmd_i.load && (in_action_i == ACT_INSERT) && !full) begin
      we = 1'b1;
    end else if (cmd_i.shift && vld_d1_q) begin
      we    = 1'b1;
      waddr = idx_d1_q - AW'(1);
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    idx_d    = idx_q;
    vld_d1_d = 1'b0;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.shift_init) begin
      idx_d = CW'(best_idx_q) + CW'(1);
    end else if (re) begin
      idx_d    = idx_q + CW'(1);
      vld_d1_d = 1'b1;
    end
  end

  assign take_best = cmd_i.scan && vld_d1_q &&
                     ((idx_d1_q == '0) || (rdata_q.prio > best_q.prio));

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_q     <= rdata_q;
      best_idx_q <= idx_d1_q;
    end
    if (re) begin
      idx_d1_q <= idx_q[AW-1:0];
    end
    if (cmd_i.load) begin
      req_action_q <= in_action_i;
    end
  end

  always_comb begin
    fill_d     = fill_q;
    res_status = ST_INSERTED;
    if (req_action_q == ACT_INSERT) begin
      if (full) begin
        res_status = ST_OVERFLOW;
      end else begin
        res_status = ST_INSERTED;
        fill_d     = fill_q + CW'(1);
      end
    end else begin
      if (fill_q == '0) begin
        res_status = ST_UNDERFLOW;
      end else begin
        res_status = ST_REMOVED;
        fill_d     = fill_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      idx_q    <= '0;
      vld_d1_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      vld_d1_q <= vld_d1_d;
      if (cmd_i.finish) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_count_q  <= COUNT_W'(fill_d);
      if (res_status == ST_REMOVED) begin
        out_value_q <= best_q.value;
        out_prio_q  <= best_q.prio;
      end else begin
        out_value_q <= '0;
        out_prio_q  <= '0;
      end
    end
  end

  assign stat_o.in_remove  = (in_action_i == ACT_REMOVE);
  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.scan_done  = vld_d1_q && (CW'(idx_d1_q) == (fill_q - CW'(1)));
  assign stat_o.shift_done = !vld_d1_q && (idx_q >= fill_q);

  assign out_status_o           = out_status_q;
  assign out_removed_value_o    = out_value_q;
  assign out_removed_priority_o = out_prio_q;
  assign out_count_o            = out_count_q;

  `PQMS_ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CW'(DEPTH))
  `PQMS_ASSERT_IMPLIES(a_read_in_range, clk_i, rst_ni, vld_d1_q, CW'(idx_d1_q) < fill_q)
  `PQMS_ASSERT_NEXT(a_remove_count, clk_i, rst_ni, cmd_i.finish && req_action_q == ACT_REMOVE && fill_q != '0, fill_q == $past(fill_q) - CW'(1))

endmodule

### rtl/priority_queue_max_scan_top.sv
// ---------------------------------------------------------------------------
// Priority queue with maximum scan
// Insert appends an entry; remove returns the oldest highest-priority entry.
// An insert, overflow or underflow beat goes from acceptance straight to the done state, which loads its result.
// A remove scans all n entries, where n is the fill count, then moves the m = n - 1 - p entries
// above the removed position p down by one place, then loads its result.
// The scan reads one entry a cycle and the shift moves one entry a cycle.
// Throughput: one beat at a time; the next beat is accepted the cycle after the result loads.
// Reset clears the fill count and control state; the entry memory is not cleared.
// ---------------------------------------------------------------------------
module priority_queue_max_scan_top #(
  parameter int unsigned DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  pqms_req_if.sink   in_i,
  pqms_rsp_if.source out_o
);
  import pqms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pqms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pqms_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .in_action_i            (in_i.action),
    .in_value_i             (in_i.value),
    .in_priority_req_i      (in_i.priority_req),
    .out_status_o           (out_o.status),
    .out_removed_value_o    (out_o.removed_value),
    .out_removed_priority_o (out_o.removed_priority),
    .out_count_o            (out_o.count)
  );

endmodule
